// ===== rtl/core/csvp_pkg.sv =====
// ----------------------------------------------------------------------------
// csvp_pkg
// Types and constants shared by the CSV signed integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned VAL_W       = 32;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ENTRIES);
  localparam logic [VAL_W-1:0] STOP_RESET = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EOF     = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
    logic                    is_final;
    logic                    out_of_range;
  } result_t;

endpackage : csvp_pkg

`default_nettype wire

// ===== rtl/core/csvp_in_reg.sv =====
// ----------------------------------------------------------------------------
// csvp_in_reg
// Input register: holds one item until the parse stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire csvp_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output csvp_pkg::item_t      item
);
  import csvp_pkg::*;

  logic take;

  assign take     = !item_valid || advance;
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      item <= in_item;
    end
  end

endmodule : csvp_in_reg

`default_nettype wire

// ===== rtl/core/csvp_parse_core.sv =====
// ----------------------------------------------------------------------------
// csvp_parse_core
// Parser state, stop register and the per-item update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_parse_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [csvp_pkg::VAL_W-1:0]     cfg_data,
  input  wire logic                           fire,
  input  wire csvp_pkg::item_t                item,
  output logic                                res_valid,
  output csvp_pkg::result_t                   res
);
  import csvp_pkg::*;

  logic [VAL_W-1:0] stop_value;
  logic [VAL_W-1:0] accumulator, accumulator_next;
  logic [POS_W-1:0] position, position_next;
  logic negative_mode, negative_mode_next;
  logic slash_seen, slash_seen_next;
  logic skipping_line, skipping_line_next;
  logic end_marker_seen, end_marker_seen_next;
  logic finished, finished_next;

  logic [VAL_W-1:0] acc_times10;
  logic [VAL_W-1:0] digit;
  logic [VAL_W-1:0] acc_digit;
  logic [VAL_W-1:0] emit_value;
  logic             emit_final;
  logic [7:0]       c;

  assign c           = item.text_byte;
  assign acc_times10 = (accumulator << 3) + (accumulator << 1);
  assign digit       = VAL_W'(c - CH_0);
  assign acc_digit   = negative_mode ? (acc_times10 - digit) : (acc_times10 + digit);

  always_comb begin
    accumulator_next     = accumulator;
    position_next        = position;
    negative_mode_next   = negative_mode;
    slash_seen_next      = slash_seen;
    skipping_line_next   = skipping_line;
    end_marker_seen_next = end_marker_seen;
    finished_next        = finished;
    res_valid            = 1'b0;
    emit_value           = accumulator;
    emit_final           = 1'b0;

    if (fire) begin
      case (item.kind)
        KIND_RESTART: begin
          accumulator_next     = '0;
          position_next        = '0;
          negative_mode_next   = 1'b0;
          slash_seen_next      = 1'b0;
          skipping_line_next   = 1'b0;
          end_marker_seen_next = 1'b0;
          finished_next        = 1'b0;
        end
        KIND_EOF: begin
          if (!finished) begin
            res_valid     = 1'b1;
            emit_final    = 1'b1;
            finished_next = 1'b1;
          end
        end
        KIND_BYTE: begin
          if (!finished) begin
            if (skipping_line) begin
              if (c == CH_LF) begin
                skipping_line_next = 1'b0;
                slash_seen_next    = 1'b0;
              end
            end else if (c == CH_NUL || (c == CH_SLASH && slash_seen)) begin
              slash_seen_next = 1'b0;
              if (end_marker_seen) begin
                res_valid     = 1'b1;
                emit_final    = 1'b1;
                finished_next = 1'b1;
              end else begin
                skipping_line_next = 1'b1;
              end
            end else begin
              slash_seen_next = (c == CH_SLASH);
              if (c == CH_COMMA || c == CH_LF) begin
                res_valid          = 1'b1;
                emit_final         = (c == CH_LF) && end_marker_seen;
                finished_next      = emit_final;
                accumulator_next   = '0;
                negative_mode_next = 1'b0;
                if (position < POS_LIMIT) begin
                  position_next = position + 1'b1;
                end
              end else if (c == CH_MINUS) begin
                negative_mode_next = 1'b1;
              end else if (c == CH_AT) begin
                end_marker_seen_next = 1'b1;
              end else if (c inside {[CH_0:CH_9]}) begin
                accumulator_next = acc_digit;
                emit_value       = acc_digit;
                if (acc_digit == stop_value) begin
                  res_valid     = 1'b1;
                  emit_final    = 1'b1;
                  finished_next = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.element_index = position;
    res.element_value = $signed(emit_value);
    res.is_final      = emit_final;
    res.out_of_range  = (position >= POS_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_value <= STOP_RESET;
    end else if (cfg_write) begin
      stop_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      position        <= '0;
      negative_mode   <= 1'b0;
      slash_seen      <= 1'b0;
      skipping_line   <= 1'b0;
      end_marker_seen <= 1'b0;
      finished        <= 1'b0;
    end else begin
      accumulator     <= accumulator_next;
      position        <= position_next;
      negative_mode   <= negative_mode_next;
      slash_seen      <= slash_seen_next;
      skipping_line   <= skipping_line_next;
      end_marker_seen <= end_marker_seen_next;
      finished        <= finished_next;
    end
  end

endmodule : csvp_parse_core

`default_nettype wire

// ===== rtl/core/csvp_out_reg.sv =====
// ----------------------------------------------------------------------------
// csvp_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire csvp_pkg::result_t res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output csvp_pkg::result_t      out_res
);
  import csvp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_valid) begin
      out_res <= res;
    end
  end

endmodule : csvp_out_reg

`default_nettype wire

// ===== rtl/core/csv_signed_integer_parser.sv =====
// ----------------------------------------------------------------------------
// csv_signed_integer_parser
// Streaming parser of comma/newline separated signed decimal integers.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register; its result is then registered
//   in the result register when that register is free.
// Throughput: one item per cycle while the result register is free, bounded
//   by the state update (multiply by ten, add digit, compare with stop value).
// Reset: synchronous; clears parser state and both stage registers,
//   stop value returns to 0x7FFFFFFF.
`timescale 1ns / 1ps
`default_nettype none

module csv_signed_integer_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 kind,
  input  wire logic [7:0]                 text_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [csvp_pkg::POS_W-1:0]      element_index,
  output logic signed [csvp_pkg::VAL_W-1:0] element_value,
  output logic                            is_final,
  output logic                            out_of_range,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [csvp_pkg::VAL_W-1:0] cfg_data
);
  import csvp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    free;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.kind      = kind;
  assign in_item.text_byte = text_byte;
  assign cfg_ready         = 1'b1;
  assign advance           = item_valid && free;

  csvp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  csvp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  csvp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign element_index = out_res.element_index;
  assign element_value = out_res.element_value;
  assign is_final      = out_res.is_final;
  assign out_of_range  = out_res.out_of_range;

endmodule : csv_signed_integer_parser

`default_nettype wire

// ===== rtl/core/csvp_checker.sv =====
// ----------------------------------------------------------------------------
// csvp_checker
// Port-level checks for the CSV signed integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [1:0]                   kind,
  input wire logic [7:0]                   text_byte,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [csvp_pkg::POS_W-1:0]   element_index,
  input wire logic [csvp_pkg::VAL_W-1:0]   element_value,
  input wire logic                         is_final,
  input wire logic                         out_of_range
);
  import csvp_pkg::*;

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_range_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_of_range == (element_index == POS_LIMIT)))
    else $error("out_of_range disagrees with saturated index");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(element_index) && $stable(element_value)
      && $stable(is_final) && $stable(out_of_range))
    else $error("stalled result changed");

  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(kind) && $stable(text_byte))
    else $error("stalled input transfer changed");

endmodule : csvp_checker

bind csv_signed_integer_parser csvp_checker u_csvp_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for csv_signed_integer_parser. A directed table comes
// first, then random text streams under several stop values and idling mixes.
// Output is checked against typed rows or a behavioural parser in the bench.
// ----------------------------------------------------------------------------

module tb_top;
  import csvp_pkg::*;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       text_byte;
    logic             typed;
    logic [POS_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             fin;
    logic             oor;
  } row_t;

  localparam int N_ROWS = 27;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{KIND_BYTE,    "1",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "2",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_COMMA, 1'b1, 13'd0, 32'd12,         1'b0, 1'b0},
    '{KIND_BYTE,    CH_MINUS, 1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "7",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_LF,    1'b1, 13'd1, 32'hFFFF_FFF9,  1'b0, 1'b0},
    '{KIND_BYTE,    CH_SLASH, 1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_SLASH, 1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "9",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_LF,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    8'hFF,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_NUL,   1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_LF,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_SLASH, 1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "4",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_SLASH, 1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_COMMA, 1'b1, 13'd2, 32'd4,          1'b0, 1'b0},
    '{KIND_RSVD,    8'hFF,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_AT,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "5",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    CH_LF,    1'b1, 13'd3, 32'd5,          1'b1, 1'b0},
    '{KIND_BYTE,    "6",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_EOF,     8'h00,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_RESTART, 8'h00,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_BYTE,    "3",      1'b0, 13'd0, 32'd0,          1'b0, 1'b0},
    '{KIND_EOF,     8'h00,    1'b1, 13'd0, 32'd3,          1'b1, 1'b0},
    '{KIND_RESTART, 8'h00,    1'b0, 13'd0, 32'd0,          1'b0, 1'b0}
  };

  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 200;
  localparam logic [VAL_W-1:0] STOPS [N_PHASES] = '{
    32'h8000_0000, 32'd42, 32'hFFFF_FFFD, 32'd0, 32'd0, STOP_RESET
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              kind = 2'd0;
  logic [7:0]              text_byte = 8'd0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [POS_W-1:0]        element_index;
  logic signed [VAL_W-1:0] element_value;
  logic                    is_final;
  logic                    out_of_range;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [VAL_W-1:0]        cfg_data = '0;

  csv_signed_integer_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .text_byte     (text_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .element_index (element_index),
    .element_value (element_value),
    .is_final      (is_final),
    .out_of_range  (out_of_range),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // parser state mirror
  logic [VAL_W-1:0] stop_level;
  logic [VAL_W-1:0] run_acc;
  logic [POS_W-1:0] run_pos;
  logic             minus_on, slash_pending, skip_line, end_mark, parse_done;

  result_t pending_elements[$];
  item_t   text_stream[$];
  result_t want_el;

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int n_live = 0;
  int n_elements = 0;
  int n_final = 0;
  int n_oor = 0;
  int n_cfg = 0;

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  function automatic void clear_parse();
    run_acc       = '0;
    run_pos       = '0;
    minus_on      = 1'b0;
    slash_pending = 1'b0;
    skip_line     = 1'b0;
    end_mark      = 1'b0;
    parse_done    = 1'b0;
  endfunction

  function automatic result_t close_element(input logic fin);
    result_t r;
    r.element_index = run_pos;
    r.element_value = run_acc;
    r.is_final      = fin;
    r.out_of_range  = (run_pos >= POS_LIMIT);
    if (fin) parse_done = 1'b1;
    return r;
  endfunction

  function automatic logic parse_item(input item_t it, output result_t r);
    logic [7:0]       c;
    logic [VAL_W-1:0] digit;
    c = it.text_byte;
    r = '0;
    if (it.kind == KIND_RESTART) begin
      clear_parse();
      return 1'b0;
    end
    if (it.kind == KIND_RSVD || parse_done) return 1'b0;
    if (it.kind == KIND_EOF) begin
      r = close_element(1'b1);
      return 1'b1;
    end
    if (skip_line) begin
      if (c == CH_LF) begin
        skip_line     = 1'b0;
        slash_pending = 1'b0;
      end
      return 1'b0;
    end
    if (c == CH_NUL || (c == CH_SLASH && slash_pending)) begin
      slash_pending = 1'b0;
      if (end_mark) begin
        r = close_element(1'b1);
        return 1'b1;
      end
      skip_line = 1'b1;
      return 1'b0;
    end
    slash_pending = (c == CH_SLASH);
    if (c == CH_COMMA || c == CH_LF) begin
      r = close_element(c == CH_LF && end_mark);
      if (run_pos < POS_LIMIT) run_pos = run_pos + 1'b1;
      run_acc  = '0;
      minus_on = 1'b0;
      return 1'b1;
    end
    if (c == CH_MINUS) begin
      minus_on = 1'b1;
      return 1'b0;
    end
    if (c == CH_AT) begin
      end_mark = 1'b1;
      return 1'b0;
    end
    if (c >= CH_0 && c <= CH_9) begin
      digit   = {24'd0, c - CH_0};
      run_acc = run_acc * 10;
      run_acc = minus_on ? run_acc - digit : run_acc + digit;
      if (run_acc == stop_level) begin
        r = close_element(1'b1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_elements.size() == 0) begin
        $error("element with nothing pending: index %0d value %0d",
               element_index, element_value);
        errors++;
      end else begin
        want_el = pending_elements.pop_front();
        n_elements++;
        if (is_final) n_final++;
        if (out_of_range) n_oor++;
        if (element_index !== want_el.element_index) begin
          $error("element_index: expected %0d, got %0d",
                 want_el.element_index, element_index);
          errors++;
        end
        if (element_value !== want_el.element_value) begin
          $error("element_value: expected %0d, got %0d",
                 want_el.element_value, element_value);
          errors++;
        end
        if (is_final !== want_el.is_final) begin
          $error("is_final: expected %0d, got %0d", want_el.is_final, is_final);
          errors++;
        end
        if (out_of_range !== want_el.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d",
                 want_el.out_of_range, out_of_range);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t r;
    logic    ok;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= it.kind;
    text_byte <= it.text_byte;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (it.kind != KIND_RSVD && !parse_done) n_live++;
    if (parse_item(it, r)) pending_elements.push_back(typed ? want : r);
  endtask

  task automatic drain_elements();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_elements.size() != 0);
  endtask

  task automatic write_stop(input logic [VAL_W-1:0] v);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    stop_level = v;
    n_cfg++;
  endtask

  task automatic add_item(input logic [1:0] k, input logic [7:0] b);
    text_stream.push_back('{kind: k, text_byte: b});
  endtask

  task automatic add_number();
    string s;
    int    len;
    if ($urandom_range(0, 9) == 0) begin
      s = $sformatf("%0d", $signed(stop_level));
      for (int i = 0; i < s.len(); i++) add_item(KIND_BYTE, s[i]);
    end else begin
      if ($urandom_range(0, 3) == 0) add_item(KIND_BYTE, CH_MINUS);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
      repeat (len) add_item(KIND_BYTE, CH_0 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic build_record();
    int pick;
    pick = $urandom_range(0, 99);
    if (parse_done && $urandom_range(0, 4) != 0) pick = 70;
    if (pick < 45) begin
      add_number();
      add_item(KIND_BYTE, ($urandom_range(0, 3) == 0) ? CH_LF : CH_COMMA);
    end else if (pick < 55) begin
      if ($urandom_range(0, 1) == 0) begin
        add_item(KIND_BYTE, CH_SLASH);
        add_item(KIND_BYTE, CH_SLASH);
      end else begin
        add_item(KIND_BYTE, CH_NUL);
      end
      repeat ($urandom_range(0, 5)) add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      add_item(KIND_BYTE, CH_LF);
    end else if (pick < 63) begin
      add_item(KIND_BYTE, CH_AT);
      case ($urandom_range(0, 3))
        0: begin
          add_number();
          add_item(KIND_BYTE, CH_LF);
        end
        1: begin
          add_item(KIND_BYTE, CH_SLASH);
          add_item(KIND_BYTE, CH_SLASH);
        end
        2: add_item(KIND_BYTE, CH_NUL);
        default: begin
          add_number();
          add_item(KIND_BYTE, CH_COMMA);
        end
      endcase
    end else if (pick < 69) begin
      add_item(KIND_EOF, 8'($urandom_range(0, 255)));
    end else if (pick < 77) begin
      add_item(KIND_RESTART, 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      add_item(KIND_BYTE, CH_SLASH);
      add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    item_t   it;
    result_t want;
    result_t none;
    int      base;
    none = '0;
    clear_parse();
    stop_level = STOP_RESET;
    idle_pct   = 31;
    stall_pct  = 53;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      it.kind         = DIRECTED[i].kind;
      it.text_byte    = DIRECTED[i].text_byte;
      want.element_index = DIRECTED[i].idx;
      want.element_value = DIRECTED[i].val;
      want.is_final      = DIRECTED[i].fin;
      want.out_of_range  = DIRECTED[i].oor;
      send_item(it, DIRECTED[i].typed, want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_elements();
      repeat (8) @(posedge clk);
      write_stop((ph == 4) ? $urandom() : STOPS[ph]);
      idle_pct  = (ph < 2) ? 31 : (ph < 4) ? 53 : 0;
      stall_pct = (ph < 2) ? 53 : (ph < 4) ? 31 : 0;
      add_item(KIND_RESTART, 8'h00);
      base = n_live;
      while (n_live - base < PHASE_ITEMS) begin
        build_record();
        while (text_stream.size() != 0) send_item(text_stream.pop_front(), 1'b0, none);
        if ($urandom_range(0, 99) == 0) drain_elements();
      end
    end

    drain_elements();
    repeat (10) @(posedge clk);
    $display("Sent %0d live items over %0d stop value settings and three idling mixes.",
             n_live, n_cfg);
    $display("Checked %0d elements: %0d final, %0d past capacity.",
             n_elements, n_final, n_oor);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== csv_signed_integer_parser.f =====
rtl/core/csvp_pkg.sv
rtl/core/csvp_in_reg.sv
rtl/core/csvp_parse_core.sv
rtl/core/csvp_out_reg.sv
rtl/core/csv_signed_integer_parser.sv
rtl/core/csvp_checker.sv
test/tb_top.sv
